// ===== sv/swsr_pkg.sv =====
// Shared types and constants of the single-wire sensor frame receiver.
package swsr_pkg;

	localparam int unsigned FIELD_W     = 16;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned FRAME_BITS  = 40;
	localparam int unsigned BIT_CNT_W   = 6;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = 1;
	localparam int unsigned QCNT_W      = 2;

	// Reset values of the timing windows, in microseconds.
	localparam logic [FIELD_W-1:0] RESP_MIN_RST     = 16'd65;
	localparam logic [FIELD_W-1:0] RESP_MAX_RST     = 16'd100;
	localparam logic [FIELD_W-1:0] BIT_LOW_MIN_RST  = 16'd30;
	localparam logic [FIELD_W-1:0] BIT_LOW_MAX_RST  = 16'd70;
	localparam logic [FIELD_W-1:0] ZERO_HI_MIN_RST  = 16'd10;
	localparam logic [FIELD_W-1:0] ZERO_HI_MAX_RST  = 16'd50;
	localparam logic [FIELD_W-1:0] ONE_HI_MIN_RST   = 16'd50;
	localparam logic [FIELD_W-1:0] ONE_HI_MAX_RST   = 16'd100;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RESP_MIN    = 3'd0,
		REG_RESP_MAX    = 3'd1,
		REG_BIT_LOW_MIN = 3'd2,
		REG_BIT_LOW_MAX = 3'd3,
		REG_ZERO_HI_MIN = 3'd4,
		REG_ZERO_HI_MAX = 3'd5,
		REG_ONE_HI_MIN  = 3'd6,
		REG_ONE_HI_MAX  = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NO_RESPONSE = 2'd1,
		ST_BAD_BIT     = 2'd2,
		ST_CHECKSUM    = 2'd3
	} status_t;

	// What the front end decided about one pulse pair.
	typedef enum logic [2:0] {
		K_START_OK  = 3'd0,
		K_START_BAD = 3'd1,
		K_BIT_ZERO  = 3'd2,
		K_BIT_ONE   = 3'd3,
		K_BIT_BAD   = 3'd4
	} kind_t;

endpackage

// ===== sv/swsr_front.sv =====
// Front end: window registers and classification of each pulse pair.
module swsr_front #(
	parameter int unsigned DURATION_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [swsr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [swsr_pkg::FIELD_W-1:0]        cfg_data,
	input  logic                                frame_start,
	input  logic [swsr_pkg::FIELD_W-1:0]        first_level_us,
	input  logic [swsr_pkg::FIELD_W-1:0]        second_level_us,
	input  logic                                timed_out,
	output swsr_pkg::kind_t                     kind
);
	import swsr_pkg::*;

	// Durations compare on their low DURATION_WIDTH bits, never more than the field.
	localparam int unsigned CMP_W = (DURATION_WIDTH < FIELD_W) ? DURATION_WIDTH : FIELD_W;

	logic [CMP_W-1:0] resp_min_q, resp_max_q;
	logic [CMP_W-1:0] low_min_q, low_max_q;
	logic [CMP_W-1:0] zero_min_q, zero_max_q;
	logic [CMP_W-1:0] one_min_q, one_max_q;

	logic [CMP_W-1:0] first_d, second_d, wr_d;
	logic             resp_ok, low_ok, zero_ok, one_ok;

	assign first_d  = first_level_us[CMP_W-1:0];
	assign second_d = second_level_us[CMP_W-1:0];
	assign wr_d     = cfg_data[CMP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_min_q <= RESP_MIN_RST[CMP_W-1:0];
			resp_max_q <= RESP_MAX_RST[CMP_W-1:0];
			low_min_q  <= BIT_LOW_MIN_RST[CMP_W-1:0];
			low_max_q  <= BIT_LOW_MAX_RST[CMP_W-1:0];
			zero_min_q <= ZERO_HI_MIN_RST[CMP_W-1:0];
			zero_max_q <= ZERO_HI_MAX_RST[CMP_W-1:0];
			one_min_q  <= ONE_HI_MIN_RST[CMP_W-1:0];
			one_max_q  <= ONE_HI_MAX_RST[CMP_W-1:0];
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RESP_MIN:    resp_min_q <= wr_d;
				REG_RESP_MAX:    resp_max_q <= wr_d;
				REG_BIT_LOW_MIN: low_min_q  <= wr_d;
				REG_BIT_LOW_MAX: low_max_q  <= wr_d;
				REG_ZERO_HI_MIN: zero_min_q <= wr_d;
				REG_ZERO_HI_MAX: zero_max_q <= wr_d;
				REG_ONE_HI_MIN:  one_min_q  <= wr_d;
				REG_ONE_HI_MAX:  one_max_q  <= wr_d;
				default:         resp_min_q <= resp_min_q;
			endcase
		end
	end

	// Inclusive windows; an inverted window simply never matches.
	assign resp_ok = !timed_out
		&& (first_d >= resp_min_q) && (first_d <= resp_max_q)
		&& (second_d >= resp_min_q) && (second_d <= resp_max_q);
	assign low_ok  = !timed_out && (first_d >= low_min_q) && (first_d <= low_max_q);
	assign zero_ok = (second_d >= zero_min_q) && (second_d <= zero_max_q);
	assign one_ok  = (second_d >= one_min_q) && (second_d <= one_max_q);

	// The zero window wins where the two overlap.
	always_comb begin
		priority if (frame_start && resp_ok)  kind = K_START_OK;
		else if (frame_start)                 kind = K_START_BAD;
		else if (low_ok && zero_ok)           kind = K_BIT_ZERO;
		else if (low_ok && one_ok)            kind = K_BIT_ONE;
		else                                  kind = K_BIT_BAD;
	end

endmodule

// ===== sv/swsr_queue.sv =====
// Two-entry queue of classified pairs between front end and frame assembler.
module swsr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  swsr_pkg::kind_t push_kind,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output swsr_pkg::kind_t head_kind
);
	import swsr_pkg::*;

	kind_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push, do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head_kind = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");
	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue pop did not lower the count");
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !do_pop) |=> full)
		else $error("full queue drained without a pop");
`endif

endmodule

// ===== sv/swsr_back.sv =====
// Back end: frame assembly, checksum test and the result register.
module swsr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  swsr_pkg::kind_t               q_kind,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [swsr_pkg::FIELD_W-1:0]  humidity_raw,
	output logic [swsr_pkg::FIELD_W-1:0]  temperature_raw
);
	import swsr_pkg::*;

	logic                   in_frame_q, in_frame_d;
	logic [BIT_CNT_W-1:0]   bits_q, bits_d;
	logic [FRAME_BITS-1:0]  shift_q, shift_d, shift_next;
	logic                   bad_q, bad_d;

	logic                   out_valid_q;
	status_t                status_q;
	logic [FIELD_W-1:0]     hum_q, temp_q;

	logic                   res_fire;
	status_t                res_status;
	logic [FIELD_W-1:0]     res_hum, res_temp;
	logic                   bit_val, bit_bad, last_bit;
	logic [7:0]             sum;

	// A queued pair moves on whenever the result register can take a result.
	assign q_pop = q_valid && (!out_valid_q || !out_stall);

	assign bit_val    = (q_kind == K_BIT_ONE);
	assign bit_bad    = (q_kind == K_BIT_BAD);
	assign shift_next = {shift_q[FRAME_BITS-2:0], bit_val};
	assign last_bit   = (bits_q == BIT_CNT_W'(FRAME_BITS - 1));
	assign sum        = shift_next[39:32] + shift_next[31:24]
	                  + shift_next[23:16] + shift_next[15:8];

	always_comb begin
		in_frame_d = in_frame_q;
		bits_d     = bits_q;
		shift_d    = shift_q;
		bad_d      = bad_q;
		res_fire   = 1'b0;
		res_status = ST_OK;
		res_hum    = '0;
		res_temp   = '0;
		if (q_pop) begin
			unique case (q_kind)
				K_START_OK, K_START_BAD: begin
					in_frame_d = (q_kind == K_START_OK);
					bits_d     = '0;
					shift_d    = '0;
					bad_d      = 1'b0;
					if (q_kind == K_START_BAD) begin
						res_fire   = 1'b1;
						res_status = ST_NO_RESPONSE;
					end
				end
				K_BIT_ZERO, K_BIT_ONE, K_BIT_BAD: begin
					if (in_frame_q) begin
						shift_d = shift_next;
						bad_d   = bad_q || bit_bad;
						bits_d  = bits_q + 1'b1;
						if (last_bit) begin
							in_frame_d = 1'b0;
							bits_d     = '0;
							res_fire   = 1'b1;
							priority if (bad_q || bit_bad) begin
								res_status = ST_BAD_BIT;
							end else if (sum != shift_next[7:0]) begin
								res_status = ST_CHECKSUM;
							end else begin
								res_status = ST_OK;
								res_hum    = shift_next[39:24];
								res_temp   = shift_next[23:8];
							end
						end
					end
				end
				default: begin
					in_frame_d = in_frame_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			bits_q      <= '0;
			shift_q     <= '0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			in_frame_q <= in_frame_d;
			bits_q     <= bits_d;
			shift_q    <= shift_d;
			bad_q      <= bad_d;
			if (res_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			status_q <= res_status;
			hum_q    <= res_hum;
			temp_q   <= res_temp;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign humidity_raw    = hum_q;
	assign temperature_raw = temp_q;

`ifndef NO_ASSERTIONS
	a_bits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q < BIT_CNT_W'(FRAME_BITS))
		else $error("bit count ran past the frame length");
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (bits_q == '0))
		else $error("bit count nonzero outside a frame");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> (hum_q == '0 && temp_q == '0))
		else $error("error result carries data");
`endif

endmodule

// ===== sv/single_wire_sensor_frame_receiver.sv =====
// Top level of the single-wire sensor frame receiver.
//
//  Chan  Dir     Handshake              Payload
//  in    sink    in_valid / in_stall    frame_start, first_level_us, second_level_us, timed_out
//  out   source  out_valid / out_stall  status, humidity_raw, temperature_raw
//  cfg   sink    cfg_we                 cfg_index, cfg_data
//
// One pulse pair is taken every cycle while in_stall is low. A transferred pair is written into
// the queue; the frame assembler takes it from the queue head and loads any result into the
// output register as it does so, and the result is transferred from that register.
// The rate of one pair per cycle, while no stall holds it, comes from the queue handing one pair
// per cycle to the assembler, which finishes each pair as it takes it.
// Reset clears the frame state and the queue and loads the default timing windows.
// An output stall holds the result; the queue keeps taking pairs until it is full,
// and only then is in_stall raised.
module single_wire_sensor_frame_receiver #(
	parameter int unsigned DURATION_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [swsr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [swsr_pkg::FIELD_W-1:0]        cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                frame_start,
	input  logic [swsr_pkg::FIELD_W-1:0]        first_level_us,
	input  logic [swsr_pkg::FIELD_W-1:0]        second_level_us,
	input  logic                                timed_out,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          status,
	output logic [swsr_pkg::FIELD_W-1:0]        humidity_raw,
	output logic [swsr_pkg::FIELD_W-1:0]        temperature_raw
);
	import swsr_pkg::*;

	kind_t front_kind, head_kind;
	logic  q_full, q_not_empty, q_pop;

	// The front end classifies each pair against the windows as it arrives.
	swsr_front #(
		.DURATION_WIDTH(DURATION_WIDTH)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.frame_start     (frame_start),
		.first_level_us  (first_level_us),
		.second_level_us (second_level_us),
		.timed_out       (timed_out),
		.kind            (front_kind)
	);

	// A transfer pushes the classified pair; the stall is just the queue being full.
	assign in_stall = q_full;

	swsr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid),
		.push_kind (front_kind),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head_kind (head_kind)
	);

	// The back end builds the 40-bit frame and issues at most one result per pair.
	swsr_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_not_empty),
		.q_kind          (head_kind),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.humidity_raw    (humidity_raw),
		.temperature_raw (temperature_raw)
	);

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench of the single-wire sensor frame receiver.
module testbench;
	import swsr_pkg::*;

	// Apart from the reset wait, the stimulus and the checker never wait on a fixed delay except these.
	localparam int SETTLE_CYCLES = 8;      // lets a pair pass the queue and the output register
	localparam int CYCLE_LIMIT   = 200000; // well above the slowest correct run
	localparam int NUM_SETTINGS  = 6;

	// One measured pulse pair, as it crosses the input channel.
	typedef struct packed {
		logic        start;
		logic [15:0] first;
		logic [15:0] second;
		logic        tmo;
	} sensor_pair_t;

	// One decoded frame outcome, as it crosses the output channel.
	typedef struct packed {
		status_t     status;
		logic [15:0] humidity;
		logic [15:0] temperature;
	} reading_t;

	// How the durations of a data bit are chosen. The fixed styles assume
	// the reset windows; the window style draws from the current windows.
	typedef enum logic [2:0] {
		TM_NOMINAL,
		TM_EDGE_LO,
		TM_EDGE_HI,
		TM_ONE_AT_50,
		TM_WINDOW
	} bit_timing_t;

	// How a data pair is spoiled when its position is marked in a fault mask.
	typedef enum logic [2:0] {
		FAULT_NONE,
		FAULT_TIMEOUT,
		FAULT_LOW_SHORT,
		FAULT_LOW_LONG,
		FAULT_HIGH_SHORT,
		FAULT_HIGH_LONG,
		FAULT_NOISE
	} pair_fault_t;

	// One row of the directed table: an optional handshake, then data bits.
	// Mask and word bit 39 belong to the first data pair sent.
	typedef struct packed {
		logic        with_hs;
		logic        hs_tmo;
		logic [15:0] hs_first;
		logic [15:0] hs_second;
		int          nbits;
		logic [39:0] word;
		bit_timing_t timing;
		logic [39:0] fault_mask;
		pair_fault_t fault;
		logic        typed;
		status_t     status;
		logic [15:0] humidity;
		logic [15:0] temperature;
	} dir_case_t;

	logic        clk;
	logic        arst_n          = 1'b0;
	logic        cfg_we          = 1'b0;
	cfg_reg_t    cfg_index       = REG_RESP_MIN;
	logic [15:0] cfg_data        = 16'h0;
	logic        in_valid        = 1'b0;
	logic        in_stall;
	logic        frame_start     = 1'b0;
	logic [15:0] first_level_us  = 16'h0;
	logic [15:0] second_level_us = 16'h0;
	logic        timed_out       = 1'b0;
	logic        out_valid;
	logic        out_stall       = 1'b0;
	logic [1:0]  status;
	logic [15:0] humidity_raw;
	logic [15:0] temperature_raw;

	single_wire_sensor_frame_receiver uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.frame_start     (frame_start),
		.first_level_us  (first_level_us),
		.second_level_us (second_level_us),
		.timed_out       (timed_out),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.humidity_raw    (humidity_raw),
		.temperature_raw (temperature_raw)
	);

	// Shadow copy of the timing windows and of the frame assembler.
	logic [15:0] windows [8];
	logic        rx_open;
	int          rx_count;
	logic [39:0] rx_shift;
	logic        rx_bad;

	// Readings that the block owes, oldest first.
	reading_t    pending_readings [$];

	int error_count       = 0;
	int cycle_count       = 0;
	int counted_pairs     = 0; // pairs that the block did not simply ignore
	int send_idle_pct     = 0;
	int stall_pct         = 0;

	// Idle phases, applied in rotation: none, sender idle, receiver stall, both.
	int send_idle_of [4] = '{0, 82, 0, 22};
	int stall_of     [4] = '{0, 0, 82, 22};

	// Window sets in register order. The first is the reset state and is never
	// written; the last restores the reset values by explicit writes.
	logic [15:0] window_sets [NUM_SETTINGS][8] = '{
		'{RESP_MIN_RST, RESP_MAX_RST, BIT_LOW_MIN_RST, BIT_LOW_MAX_RST,
		  ZERO_HI_MIN_RST, ZERO_HI_MAX_RST, ONE_HI_MIN_RST, ONE_HI_MAX_RST},
		'{16'd40, 16'd60, 16'd20, 16'd40, 16'd5, 16'd25, 16'd30, 16'd70},
		'{16'd0, 16'd65535, 16'd0, 16'd65535, 16'd0, 16'd32767, 16'd32768, 16'd65535},
		'{16'd0, 16'd200, 16'd1, 16'd65535, 16'd60, 16'd10, 16'd0, 16'd65535},
		'{16'd65535, 16'd0, 16'd30, 16'd70, 16'd10, 16'd50, 16'd50, 16'd100},
		'{RESP_MIN_RST, RESP_MAX_RST, BIT_LOW_MIN_RST, BIT_LOW_MAX_RST,
		  ZERO_HI_MIN_RST, ZERO_HI_MAX_RST, ONE_HI_MIN_RST, ONE_HI_MAX_RST}
	};

	// Counted pairs of random stimulus per window set. With the inverted
	// response window every handshake fails and the bits that follow are
	// ignored, so that set gets a small share.
	int pair_quota [NUM_SETTINGS] = '{120, 110, 110, 90, 30, 120};

	// Directed rows, all under the reset windows. Status, humidity and
	// temperature are typed in where the outcome is obvious; the two untyped
	// rows produce no reading and only move the frame state.
	dir_case_t directed_cases [19] = '{
		// Handshake with a timeout, handshakes just outside the window, then extreme durations.
		'{1'b1, 1'b1, 16'd80, 16'd80, 0, 40'h0, TM_NOMINAL, 40'h0, FAULT_NONE,
		  1'b1, ST_NO_RESPONSE, 16'h0, 16'h0},
		'{1'b1, 1'b0, 16'd64, 16'd80, 0, 40'h0, TM_NOMINAL, 40'h0, FAULT_NONE,
		  1'b1, ST_NO_RESPONSE, 16'h0, 16'h0},
		'{1'b1, 1'b0, 16'd80, 16'd101, 0, 40'h0, TM_NOMINAL, 40'h0, FAULT_NONE,
		  1'b1, ST_NO_RESPONSE, 16'h0, 16'h0},
		'{1'b1, 1'b0, 16'd0, 16'd0, 0, 40'h0, TM_NOMINAL, 40'h0, FAULT_NONE,
		  1'b1, ST_NO_RESPONSE, 16'h0, 16'h0},
		'{1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 0, 40'h0, TM_NOMINAL, 40'h0, FAULT_NONE,
		  1'b1, ST_NO_RESPONSE, 16'h0, 16'h0},
		// Good frames with the handshake and the bit timings on their edges.
		'{1'b1, 1'b0, 16'd65, 16'd100, 40, 40'h00_0000_0000, TM_NOMINAL, 40'h0,
		  FAULT_NONE, 1'b1, ST_OK, 16'h0000, 16'h0000},
		'{1'b1, 1'b0, 16'd100, 16'd65, 40, 40'hFF_FFFF_FFFC, TM_EDGE_LO, 40'h0,
		  FAULT_NONE, 1'b1, ST_OK, 16'hFFFF, 16'hFFFF},
		'{1'b1, 1'b0, 16'd80, 16'd80, 40, 40'h02_8C80_6573, TM_EDGE_HI, 40'h0,
		  FAULT_NONE, 1'b1, ST_OK, 16'h028C, 16'h8065},
		// Checksum off by one.
		'{1'b1, 1'b0, 16'd80, 16'd80, 40, 40'h02_8C80_6574, TM_NOMINAL, 40'h0,
		  FAULT_NONE, 1'b1, ST_CHECKSUM, 16'h0, 16'h0},
		// One bad bit each: timeout, low too short or long, high too short or long.
		'{1'b1, 1'b0, 16'd80, 16'd80, 40, 40'h02_8C80_6573, TM_NOMINAL,
		  40'h80_0000_0000, FAULT_TIMEOUT, 1'b1, ST_BAD_BIT, 16'h0, 16'h0},
		'{1'b1, 1'b0, 16'd80, 16'd80, 40, 40'h02_8C80_6573, TM_NOMINAL,
		  40'h00_0000_0001, FAULT_LOW_SHORT, 1'b1, ST_BAD_BIT, 16'h0, 16'h0},
		'{1'b1, 1'b0, 16'd80, 16'd80, 40, 40'h02_8C80_6573, TM_NOMINAL,
		  40'h00_0008_0000, FAULT_LOW_LONG, 1'b1, ST_BAD_BIT, 16'h0, 16'h0},
		'{1'b1, 1'b0, 16'd80, 16'd80, 40, 40'h02_8C80_6573, TM_NOMINAL,
		  40'h04_0000_0000, FAULT_HIGH_SHORT, 1'b1, ST_BAD_BIT, 16'h0, 16'h0},
		'{1'b1, 1'b0, 16'd80, 16'd80, 40, 40'h02_8C80_6573, TM_NOMINAL,
		  40'h00_0000_0040, FAULT_HIGH_LONG, 1'b1, ST_BAD_BIT, 16'h0, 16'h0},
		// Every one bit sent with a 50 us high level reads as zero.
		'{1'b1, 1'b0, 16'd80, 16'd80, 40, 40'h02_8C80_6573, TM_ONE_AT_50, 40'h0,
		  FAULT_NONE, 1'b1, ST_OK, 16'h0000, 16'h0000},
		// A frame cut short, dropped by the next handshake.
		'{1'b1, 1'b0, 16'd80, 16'd80, 20, 40'hFF_FFF0_0000, TM_NOMINAL, 40'h0,
		  FAULT_NONE, 1'b0, ST_OK, 16'h0, 16'h0},
		'{1'b1, 1'b0, 16'd80, 16'd80, 40, 40'h01_2345_67D0, TM_NOMINAL, 40'h0,
		  FAULT_NONE, 1'b1, ST_OK, 16'h0123, 16'h4567},
		// Data pairs with no frame open are ignored.
		'{1'b0, 1'b0, 16'd0, 16'd0, 3, 40'hA0_0000_0000, TM_NOMINAL, 40'h0,
		  FAULT_NONE, 1'b0, ST_OK, 16'h0, 16'h0},
		'{1'b1, 1'b0, 16'd80, 16'd80, 40, 40'hA5_5AC3_3CFE, TM_NOMINAL, 40'h0,
		  FAULT_NONE, 1'b1, ST_OK, 16'hA55A, 16'hC33C}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A run that stalls somewhere ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic in_span(input logic [15:0] v, input logic [15:0] lo,
		input logic [15:0] hi);
		return v >= lo && v <= hi;
	endfunction

	// Advances the shadow frame assembler by one accepted pair. Returns 1 and
	// fills the reading when the pair completes a frame or fails a handshake.
	function automatic logic decode_pair(input sensor_pair_t p, output reading_t r);
		logic       bit_val;
		logic       low_ok;
		logic [7:0] sum;
		r = '{ST_OK, 16'h0, 16'h0};
		if (p.start) begin
			// A handshake always restarts the assembler, good or bad.
			rx_open  = !p.tmo
				&& in_span(p.first, windows[REG_RESP_MIN], windows[REG_RESP_MAX])
				&& in_span(p.second, windows[REG_RESP_MIN], windows[REG_RESP_MAX]);
			rx_count = 0;
			rx_shift = 40'h0;
			rx_bad   = 1'b0;
			if (!rx_open) begin
				r.status = ST_NO_RESPONSE;
				return 1'b1;
			end
			return 1'b0;
		end
		if (!rx_open)
			return 1'b0;

		// The zero window wins where the two high-level windows overlap.
		low_ok  = !p.tmo && in_span(p.first, windows[REG_BIT_LOW_MIN], windows[REG_BIT_LOW_MAX]);
		bit_val = 1'b0;
		if (low_ok && in_span(p.second, windows[REG_ZERO_HI_MIN], windows[REG_ZERO_HI_MAX]))
			bit_val = 1'b0;
		else if (low_ok && in_span(p.second, windows[REG_ONE_HI_MIN], windows[REG_ONE_HI_MAX]))
			bit_val = 1'b1;
		else
			rx_bad = 1'b1;
		rx_shift = {rx_shift[38:0], bit_val};
		rx_count++;
		if (rx_count < FRAME_BITS)
			return 1'b0;

		rx_open  = 1'b0;
		rx_count = 0;
		if (rx_bad) begin
			r.status = ST_BAD_BIT;
			return 1'b1;
		end
		sum = rx_shift[39:32] + rx_shift[31:24] + rx_shift[23:16] + rx_shift[15:8];
		if (sum != rx_shift[7:0]) begin
			r.status = ST_CHECKSUM;
			return 1'b1;
		end
		r.humidity    = rx_shift[39:24];
		r.temperature = rx_shift[23:8];
		return 1'b1;
	endfunction

	// A duration inside [lo, hi], or any duration when the window is inverted.
	function automatic logic [15:0] pick(input int lo, input int hi);
		if (lo <= hi)
			return 16'($urandom_range(hi, lo));
		return 16'($urandom_range(65535));
	endfunction

	function automatic sensor_pair_t good_handshake();
		sensor_pair_t p;
		p.start  = 1'b1;
		p.tmo    = 1'b0;
		p.first  = pick(windows[REG_RESP_MIN], windows[REG_RESP_MAX]);
		p.second = pick(windows[REG_RESP_MIN], windows[REG_RESP_MAX]);
		return p;
	endfunction

	// A handshake that times out, misses the window on one side, or is noise.
	function automatic sensor_pair_t broken_handshake();
		sensor_pair_t p;
		int           pick_kind;
		p         = good_handshake();
		pick_kind = $urandom_range(99);
		if (pick_kind < 25)
			p.tmo = 1'b1;
		else if (pick_kind < 50)
			p.first = windows[REG_RESP_MIN] - 16'd1;
		else if (pick_kind < 75)
			p.second = windows[REG_RESP_MAX] + 16'd1;
		else begin
			p.first  = 16'($urandom_range(65535));
			p.second = 16'($urandom_range(65535));
			p.tmo    = 1'($urandom_range(1));
		end
		return p;
	endfunction

	function automatic sensor_pair_t bit_pair(input logic b, input bit_timing_t tm);
		sensor_pair_t p;
		int           one_lo;
		p.start = 1'b0;
		p.tmo   = 1'b0;
		case (tm)
			TM_NOMINAL: begin
				p.first  = 16'd50;
				p.second = b ? 16'd70 : 16'd26;
			end
			TM_EDGE_LO: begin
				p.first  = 16'd30;
				p.second = b ? 16'd51 : 16'd10;
			end
			TM_EDGE_HI: begin
				p.first  = 16'd70;
				p.second = b ? 16'd100 : 16'd50;
			end
			TM_ONE_AT_50: begin
				p.first  = 16'd50;
				p.second = b ? 16'd50 : 16'd26;
			end
			default: begin
				// Keep ones clear of the zero window where that is possible, so
				// that most random frames decode as sent.
				p.first = pick(windows[REG_BIT_LOW_MIN], windows[REG_BIT_LOW_MAX]);
				one_lo  = windows[REG_ONE_HI_MIN];
				if (windows[REG_ZERO_HI_MIN] <= windows[REG_ZERO_HI_MAX]
					&& int'(windows[REG_ZERO_HI_MAX]) >= one_lo
					&& windows[REG_ZERO_HI_MAX] < windows[REG_ONE_HI_MAX])
					one_lo = int'(windows[REG_ZERO_HI_MAX]) + 1;
				p.second = b ? pick(one_lo, windows[REG_ONE_HI_MAX])
					: pick(windows[REG_ZERO_HI_MIN], windows[REG_ZERO_HI_MAX]);
			end
		endcase
		return p;
	endfunction

	function automatic sensor_pair_t spoil_pair(input sensor_pair_t p, input pair_fault_t fault);
		sensor_pair_t q;
		q = p;
		case (fault)
			FAULT_TIMEOUT:    q.tmo    = 1'b1;
			FAULT_LOW_SHORT:  q.first  = windows[REG_BIT_LOW_MIN] - 16'd1;
			FAULT_LOW_LONG:   q.first  = windows[REG_BIT_LOW_MAX] + 16'd1;
			FAULT_HIGH_SHORT: q.second = windows[REG_ZERO_HI_MIN] - 16'd1;
			FAULT_HIGH_LONG:  q.second = windows[REG_ONE_HI_MAX] + 16'd1;
			FAULT_NOISE: begin
				q.first  = 16'($urandom_range(65535));
				q.second = 16'($urandom_range(65535));
				q.tmo    = 1'($urandom_range(1));
			end
			default: ;
		endcase
		return q;
	endfunction

	// Four random data bytes and, most of the time, their checksum.
	function automatic logic [39:0] fresh_word(input logic good_sum);
		logic [39:0] w;
		w[39:8] = $urandom;
		w[7:0]  = good_sum ? w[39:32] + w[31:24] + w[23:16] + w[15:8]
			: 8'($urandom_range(255));
		return w;
	endfunction

	function automatic void apply_idle_phase(input int phase);
		send_idle_pct = send_idle_of[phase % 4];
		stall_pct     = stall_of[phase % 4];
	endfunction

	// Offers one pair and returns at the edge of its transfer. Valid is left
	// high on purpose: the next call either replaces the payload in the same
	// step or lowers valid for an idle gap.
	task automatic send_pair(input sensor_pair_t p, input logic typed, input reading_t typed_r);
		reading_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid        <= 1'b1;
		frame_start     <= p.start;
		first_level_us  <= p.first;
		second_level_us <= p.second;
		timed_out       <= p.tmo;
		do
			@(posedge clk);
		while (in_stall);

		if (p.start || rx_open)
			counted_pairs++;
		if (decode_pair(p, r)) begin
			pending_readings.push_back(typed ? typed_r : r);
		end
	endtask

	task automatic send_frame(input logic with_hs, input sensor_pair_t hs, input int nbits,
		input logic [39:0] word, input bit_timing_t tm, input logic [39:0] fault_mask,
		input pair_fault_t fault, input logic typed, input reading_t typed_r);
		sensor_pair_t p;
		if (with_hs)
			send_pair(hs, typed, typed_r);
		for (int i = 0; i < nbits; i++) begin
			p = bit_pair(word[39-i], tm);
			if (fault_mask[39-i])
				p = spoil_pair(p, fault);
			send_pair(p, typed, typed_r);
		end
	endtask

	// Waits for the block to drain, then writes all eight window registers on
	// back-to-back cycles. Write enable stays high across the burst.
	task automatic load_windows(input int set_index);
		in_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data  <= window_sets[set_index][i];
			@(posedge clk);
			windows[i] = window_sets[set_index][i];
		end
		cfg_we <= 1'b0;
	endtask

	// One random sequence. Most are well-formed frames with random content;
	// the rest are spoiled frames, frames cut short, bursts of failed
	// handshakes and raw noise.
	task automatic random_sequence();
		reading_t    no_reading;
		logic [39:0] mask;
		pair_fault_t fault;
		int          seq_kind;
		int          n;
		no_reading = '{ST_OK, 16'h0, 16'h0};
		seq_kind   = $urandom_range(99);
		if (seq_kind < 65) begin
			send_frame(1'b1, good_handshake(), FRAME_BITS, fresh_word($urandom_range(9) != 0),
				TM_WINDOW, 40'h0, FAULT_NONE, 1'b0, no_reading);
		end else if (seq_kind < 75) begin
			mask = 40'h1 << $urandom_range(39);
			repeat ($urandom_range(2))
				mask |= 40'h1 << $urandom_range(39);
			fault = pair_fault_t'($urandom_range(FAULT_NOISE, FAULT_TIMEOUT));
			send_frame(1'b1, good_handshake(), FRAME_BITS, fresh_word(1'b1), TM_WINDOW,
				mask, fault, 1'b0, no_reading);
		end else if (seq_kind < 83) begin
			// Left open; the handshake of the next frame drops it.
			send_frame(1'b1, good_handshake(), $urandom_range(39), fresh_word(1'b1),
				TM_WINDOW, 40'h0, FAULT_NONE, 1'b0, no_reading);
		end else if (seq_kind < 91) begin
			// Back-to-back failures fill the queue when the receiver stalls.
			n = $urandom_range(6, 1);
			repeat (n)
				send_pair(broken_handshake(), 1'b0, no_reading);
		end else begin
			n = $urandom_range(8, 1);
			repeat (n)
				send_pair('{1'($urandom_range(3) == 0), 16'($urandom_range(65535)),
					16'($urandom_range(65535)), 1'($urandom_range(1))}, 1'b0, no_reading);
		end
	endtask

	// Output side: each transfer is matched against the oldest pending reading,
	// and the stall pattern for the next cycle is drawn.
	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			error_count++;
			$error("%s: expected 0x%04h, got 0x%04h", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_readings.size() == 0) begin
				error_count++;
				$error("reading with none expected: status %0d, humidity 0x%04h, temperature 0x%04h",
					status, humidity_raw, temperature_raw);
			end else begin
				want = pending_readings.pop_front();
				check_field("status", 16'(want.status), 16'(status));
				check_field("humidity_raw", want.humidity, humidity_raw);
				check_field("temperature_raw", want.temperature, temperature_raw);
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		dir_case_t    c;
		sensor_pair_t hs;
		int           base_pairs;
		int           seq_round;

		// The shadow state starts where reset leaves the block.
		for (int i = 0; i < 8; i++)
			windows[i] = window_sets[0][i];
		rx_open  = 1'b0;
		rx_count = 0;
		rx_shift = 40'h0;
		rx_bad   = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows under the reset windows, rotating through idle phases.
		foreach (directed_cases[i]) begin
			c = directed_cases[i];
			apply_idle_phase(i);
			hs.start  = 1'b1;
			hs.first  = c.hs_first;
			hs.second = c.hs_second;
			hs.tmo    = c.hs_tmo;
			send_frame(c.with_hs, hs, c.nbits, c.word, c.timing, c.fault_mask, c.fault,
				c.typed, '{c.status, c.humidity, c.temperature});
		end

		// Random part, one window set after another.
		for (int s = 0; s < NUM_SETTINGS; s++) begin
			if (s != 0)
				load_windows(s);
			base_pairs = counted_pairs;
			seq_round  = 0;
			while (counted_pairs - base_pairs < pair_quota[s]) begin
				apply_idle_phase(seq_round);
				seq_round++;
				random_sequence();
			end
		end

		// Drain, then give a late or extra reading a chance to show up.
		in_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/swsr_pkg.sv
sv/swsr_front.sv
sv/swsr_queue.sv
sv/swsr_back.sv
sv/single_wire_sensor_frame_receiver.sv
sim/testbench.sv
